/* design/lmlt_pkg.sv */
// shared types and constants for the lcd mode/line timer
// mode codes, per-mode tick lengths and the controller-to-datapath command bundle
// no dependencies
package lmlt_pkg;

    localparam int unsigned TICK_W = 7;
    localparam int unsigned LINE_W = 8;
    localparam int unsigned CNT_W  = 4;

    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;
    localparam logic [1:0] MODE_DRAW   = 2'd3;

    localparam logic [TICK_W-1:0] SEARCH_TICKS      = 7'd20;
    localparam logic [TICK_W-1:0] DRAW_TICKS        = 7'd43;
    localparam logic [TICK_W-1:0] HBLANK_TICKS      = 7'd51;
    localparam logic [TICK_W-1:0] VBLANK_LINE_TICKS = 7'd114;

    localparam logic [1:0] REG_LINE_COMPARE = 2'd0;
    localparam logic [1:0] REG_IRQ_COINC    = 2'd1;
    localparam logic [1:0] REG_IRQ_VBLANK   = 2'd2;
    localparam logic [1:0] REG_IRQ_SEARCH   = 2'd3;

    typedef struct packed {
        logic load;   // new beat taken: clear the request summary
        logic tick;   // advance the timing state by one machine tick
    } t_seq_cmd;

endpackage

/* design/lmlt_ctrl.sv */
// controller for the lcd mode/line timer
// takes input beats, issues one tick command per cycle, then holds the result beat
// depends on lmlt_pkg
module lmlt_ctrl
    import lmlt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [CNT_W-1:0] i_tick_count,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_seq_cmd         o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             take;

    assign o_in_ready  = (r_state == ST_IDLE) || ((r_state == ST_OUT) && i_out_ready);
    assign o_out_valid = (r_state == ST_OUT);
    assign take        = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd.load = 1'b0;
        o_cmd.tick = 1'b0;
        case (r_state)
            ST_IDLE, ST_OUT: begin
                if (take) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = i_tick_count;
                    // a zero tick count goes straight to the result
                    n_state    = (i_tick_count == '0) ? ST_OUT : ST_RUN;
                end else if (r_state == ST_OUT && i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RUN: begin
                o_cmd.tick = 1'b1;
                n_cnt      = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_OUT;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

/* design/lmlt_dp.sv */
// datapath for the lcd mode/line timer
// mode, tick, line and coincidence state, config registers and request summary
// depends on lmlt_pkg
module lmlt_dp
    import lmlt_pkg::*;
#(
    parameter int unsigned VISIBLE_LINES = 144,
    parameter int unsigned BLANK_LINES   = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_seq_cmd          i_cmd,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_wdata,
    output logic [1:0]        o_mode,
    output logic [LINE_W-1:0] o_line,
    output logic              o_coincidence,
    output logic              o_status_irq
);

    localparam int unsigned TOTAL_LINES = VISIBLE_LINES + BLANK_LINES;
    localparam logic [LINE_W-1:0] LAST_VIS = LINE_W'(VISIBLE_LINES);
    localparam logic [LINE_W:0]   WRAP_AT  = (LINE_W + 1)'(TOTAL_LINES);

    logic [LINE_W-1:0] r_cmp;
    logic              r_en_coinc, r_en_vblank, r_en_search;

    logic [1:0]        r_mode, n_mode;
    logic [TICK_W-1:0] r_ticks, n_ticks;
    logic [LINE_W-1:0] r_line, n_line;
    logic              r_coinc, n_coinc;
    logic              r_any, n_any;

    logic [TICK_W-1:0] ticks_inc;
    logic [LINE_W:0]   line_inc;
    logic              req;

    assign ticks_inc = r_ticks + 1'b1;
    assign line_inc  = {1'b0, r_line} + 1'b1;

    always_comb begin
        n_mode  = r_mode;
        n_ticks = r_ticks;
        n_line  = r_line;
        n_coinc = r_coinc;
        req     = 1'b0;
        if (i_cmd.tick) begin
            n_ticks = ticks_inc;
            case (r_mode)
                MODE_SEARCH: begin
                    if (ticks_inc >= SEARCH_TICKS) begin
                        n_ticks = '0;
                        n_mode  = MODE_DRAW;
                    end
                end
                MODE_DRAW: begin
                    if (ticks_inc >= DRAW_TICKS) begin
                        n_ticks = '0;
                        n_mode  = MODE_HBLANK;
                    end
                end
                MODE_HBLANK: begin
                    if (ticks_inc >= HBLANK_TICKS) begin
                        n_ticks = '0;
                        n_line  = line_inc[LINE_W-1:0];
                        n_coinc = (line_inc[LINE_W-1:0] == r_cmp);
                        req     = r_en_coinc && n_coinc;
                        if (line_inc[LINE_W-1:0] == LAST_VIS) begin
                            n_mode = MODE_VBLANK;
                            req    = req || r_en_vblank;
                        end else begin
                            n_mode = MODE_SEARCH;
                            req    = req || r_en_search;
                        end
                    end
                end
                default: begin
                    // vblank: one line per full line period, wrap at the frame end
                    if (ticks_inc >= VBLANK_LINE_TICKS) begin
                        n_ticks = '0;
                        n_line  = (line_inc >= WRAP_AT) ? '0 : line_inc[LINE_W-1:0];
                        n_coinc = (n_line == r_cmp);
                        req     = r_en_coinc && n_coinc;
                        if (n_line == '0) begin
                            n_mode = MODE_SEARCH;
                            req    = req || r_en_search;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_any = r_any;
        if (i_cmd.load) begin
            n_any = 1'b0;
        end else if (i_cmd.tick) begin
            n_any = r_any || req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp       <= '0;
            r_en_coinc  <= 1'b0;
            r_en_vblank <= 1'b0;
            r_en_search <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LINE_COMPARE: r_cmp       <= i_cfg_wdata;
                REG_IRQ_COINC:    r_en_coinc  <= i_cfg_wdata[0];
                REG_IRQ_VBLANK:   r_en_vblank <= i_cfg_wdata[0];
                REG_IRQ_SEARCH:   r_en_search <= i_cfg_wdata[0];
                default:          r_cmp       <= r_cmp;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_HBLANK;
            r_ticks <= '0;
            r_line  <= '0;
            r_coinc <= 1'b0;
            r_any   <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_ticks <= n_ticks;
            r_line  <= n_line;
            r_coinc <= n_coinc;
            r_any   <= n_any;
        end
    end

    assign o_mode        = r_mode;
    assign o_line        = r_line;
    assign o_coincidence = r_coinc;
    assign o_status_irq  = r_any;

endmodule

/* design/lcd_mode_line_timer_core.sv */
// top level of the lcd mode/line timer
// joins the controller and the datapath; depends on lmlt_pkg, lmlt_ctrl, lmlt_dp
//
// usage:
//   input stream: each beat carries tick_count in s_axis_tdata[3:0], the number of
//   machine ticks to advance. output stream: one beat per input beat with the
//   mode, line, coincidence flag and status request summary after those ticks.
//   config port: i_cfg_we with i_cfg_idx selects line compare (0), coincidence
//   request enable (1), vblank request enable (2) or search request enable (3).
// timing:
//   the datapath advances one tick per clock while the controller runs, and the
//   result beat follows the last tick; a zero count goes straight to the result.
//   the next beat is taken in the cycle its predecessor's result is taken, so a
//   new beat is not accepted before the previous result has left.
// reset:
//   synchronous active-low reset puts the timer in hblank at line 0 with all
//   config registers cleared and no beat pending.
// stalls:
//   a result beat holds steady while m_axis_tready is low; no new beat is
//   accepted until it has been taken.
module lcd_mode_line_timer_core
    import lmlt_pkg::*;
#(
    parameter int unsigned VISIBLE_LINES = 144,
    parameter int unsigned BLANK_LINES   = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] tick_count, [7:4] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [1:0] mode, [9:2] line, [10] coincidence,
                                        // [11] status_irq, [15:12] zero
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata
);

    t_seq_cmd          cmd;
    logic [1:0]        mode;
    logic [LINE_W-1:0] line;
    logic              coinc;
    logic              status_irq;

    lmlt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_tick_count (s_axis_tdata[CNT_W-1:0]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_cmd        (cmd)
    );

    lmlt_dp #(
        .VISIBLE_LINES (VISIBLE_LINES),
        .BLANK_LINES   (BLANK_LINES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_mode        (mode),
        .o_line        (line),
        .o_coincidence (coinc),
        .o_status_irq  (status_irq)
    );

    assign m_axis_tdata = {4'b0000, status_irq, coinc, line, mode};

endmodule

/* tb/sv/lmlt_timing_checker.sv */
`timescale 1ns / 1ps
// result checker for the lcd mode/line timer core: follows the config port and both streams,
// predicts every output beat and compares it field by field; depends on lmlt_pkg
module lmlt_timing_checker
    import lmlt_pkg::*;
#(
    parameter int VISIBLE_LINES = 144,
    parameter int BLANK_LINES   = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // [3:0] tick_count, [7:4] zero
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,    // [1:0] mode, [9:2] line, [10] coincidence,
                                      // [11] status_irq, [15:12] zero
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    output int          o_fail_count,
    output int          o_results_seen,
    output int          o_waiting
);

    localparam int TOTAL_LINES = VISIBLE_LINES + BLANK_LINES;

    typedef struct packed {
        logic [1:0]        mode;
        logic [LINE_W-1:0] line;
        logic              coinc;
        logic              irq;
    } t_timing_status;

    logic [7:0]        cmp_line;
    logic              en_coinc;
    logic              en_vblank;
    logic              en_search;
    logic [1:0]        mode_now;
    logic [TICK_W-1:0] ticks_now;
    logic [LINE_W-1:0] line_now;
    logic              coinc_now;

    t_timing_status status_q[$];
    int             mismatches = 0;
    int             seen = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("lmlt_timing_checker: %s wrong on result %0d: got %0d, want %0d",
                 what, seen, got, want);
        mismatches++;
    endtask

    // line change: coincidence is only refreshed here
    function automatic logic enter_line(input logic [LINE_W-1:0] next_line);
        line_now  = next_line;
        coinc_now = (line_now == cmp_line);
        return coinc_now && en_coinc;
    endfunction

    function automatic t_timing_status advance_ticks(input logic [CNT_W-1:0] count);
        int             k;
        logic           req;
        t_timing_status res;
        req = 1'b0;
        for (k = 0; k < int'(count); k++) begin
            ticks_now = ticks_now + 1'b1;
            case (mode_now)
                MODE_SEARCH: begin
                    if (ticks_now >= SEARCH_TICKS) begin
                        ticks_now = '0;
                        mode_now  = MODE_DRAW;
                    end
                end
                MODE_DRAW: begin
                    if (ticks_now >= DRAW_TICKS) begin
                        ticks_now = '0;
                        mode_now  = MODE_HBLANK;
                    end
                end
                MODE_HBLANK: begin
                    if (ticks_now >= HBLANK_TICKS) begin
                        ticks_now = '0;
                        if (enter_line(line_now + 1'b1)) req = 1'b1;
                        if (line_now == VISIBLE_LINES) begin
                            mode_now = MODE_VBLANK;
                            if (en_vblank) req = 1'b1;
                        end else begin
                            mode_now = MODE_SEARCH;
                            if (en_search) req = 1'b1;
                        end
                    end
                end
                default: begin
                    if (ticks_now >= VBLANK_LINE_TICKS) begin
                        ticks_now = '0;
                        if (int'(line_now) + 1 >= TOTAL_LINES) begin
                            if (enter_line('0)) req = 1'b1;
                        end else begin
                            if (enter_line(line_now + 1'b1)) req = 1'b1;
                        end
                        if (line_now == '0) begin
                            mode_now = MODE_SEARCH;
                            if (en_search) req = 1'b1;
                        end
                    end
                end
            endcase
        end
        res.mode  = mode_now;
        res.line  = line_now;
        res.coinc = coinc_now;
        res.irq   = req;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_timing_status want;
        if (!i_rst_n) begin
            cmp_line  = '0;
            en_coinc  = 1'b0;
            en_vblank = 1'b0;
            en_search = 1'b0;
            mode_now  = MODE_HBLANK;
            ticks_now = '0;
            line_now  = '0;
            coinc_now = 1'b0;
            status_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_LINE_COMPARE: cmp_line  = i_cfg_wdata;
                    REG_IRQ_COINC:    en_coinc  = i_cfg_wdata[0];
                    REG_IRQ_VBLANK:   en_vblank = i_cfg_wdata[0];
                    REG_IRQ_SEARCH:   en_search = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            // drain before taking the new beat so the oldest is always compared
            if (i_m_tvalid && i_m_tready) begin
                seen++;
                if (status_q.size() == 0) begin
                    report_mismatch("unrequested beat", int'(i_m_tdata), 0);
                end else begin
                    want = status_q.pop_front();
                    if (i_m_tdata[1:0] != want.mode)
                        report_mismatch("mode", i_m_tdata[1:0], want.mode);
                    if (i_m_tdata[9:2] != want.line)
                        report_mismatch("line", i_m_tdata[9:2], want.line);
                    if (i_m_tdata[10] != want.coinc)
                        report_mismatch("coincidence", i_m_tdata[10], want.coinc);
                    if (i_m_tdata[11] != want.irq)
                        report_mismatch("status_irq", i_m_tdata[11], want.irq);
                    if (i_m_tdata[15:12] != '0)
                        report_mismatch("padding", i_m_tdata[15:12], 0);
                end
            end
            if (i_s_tvalid && i_s_tready)
                status_q.push_back(advance_ticks(i_s_tdata[CNT_W-1:0]));
        end
        o_fail_count   <= mismatches;
        o_results_seen <= seen;
        o_waiting      <= status_q.size();
    end

endmodule

/* tb/sv/tb_lcd_mode_line_timer_core.sv */
`timescale 1ns / 1ps
// stimulus and verdict for lcd_mode_line_timer_core: config phases, tick beats and a stalling
// result side; depends on lmlt_pkg, lmlt_timing_checker and the core
module tb_lcd_mode_line_timer_core;
    import lmlt_pkg::*;

    localparam int VISIBLE_LINES = 144;
    localparam int BLANK_LINES   = 10;
    localparam int LINE_TICKS    = int'(VBLANK_LINE_TICKS);
    localparam int FRAME_TICKS   = (VISIBLE_LINES + BLANK_LINES) * LINE_TICKS;
    // reset leaves the timer at the start of hblank on line 0
    localparam int RESET_PHASE   = int'(SEARCH_TICKS) + int'(DRAW_TICKS);
    localparam int MAX_COUNT     = 15;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 2_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [3:0] tick_count, [7:4] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // [1:0] mode, [9:2] line, [10] coincidence,
                                  // [11] status_irq, [15:12] zero
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [7:0]  i_cfg_wdata;

    int fail_count;
    int results_seen;
    int waiting;
    int beats_sent;
    int ticks_sent;
    int ready_hold;
    bit quiet;

    // opening beats: crosses the first hblank end, a full search and draw, all counts 0..15
    int opening_counts [25] = '{0, 15, 15, 15, 5, 1, 8, 8, 4, 15, 15, 13, 9, 10, 11, 12,
                                8, 1, 2, 3, 6, 7, 14, 0, 8};

    lcd_mode_line_timer_core #(
        .VISIBLE_LINES (VISIBLE_LINES),
        .BLANK_LINES   (BLANK_LINES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    lmlt_timing_checker #(
        .VISIBLE_LINES (VISIBLE_LINES),
        .BLANK_LINES   (BLANK_LINES)
    ) timing_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_axis_tvalid),
        .i_s_tready     (s_axis_tready),
        .i_s_tdata      (s_axis_tdata),
        .i_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .i_m_tdata      (m_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_fail_count   (fail_count),
        .o_results_seen (results_seen),
        .o_waiting      (waiting)
    );

    always #2 i_clk = ~i_clk;

    // result side: random stall bursts between runs of readiness
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            ready_hold    <= $urandom_range(0, 15);
        end else begin
            m_axis_tready <= 1'b1;
            ready_hold    <= $urandom_range(0, 24);
        end
    end

    task automatic send_beat(input logic [CNT_W-1:0] count);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, count};
        do @(posedge i_clk); while (!s_axis_tready);
        beats_sent++;
        ticks_sent += int'(count);
    endtask

    function automatic logic [CNT_W-1:0] rand_count();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '0;
        if (pick <= 2) return CNT_W'($urandom_range(9, 15));
        return CNT_W'($urandom_range(1, 8));
    endfunction

    task automatic random_run(input int beats);
        for (int n = 0; n < beats; n++) send_beat(rand_count());
    endtask

    // long beats until the frame position sits 'lead' ticks before the given line starts
    task automatic run_to_line(input int target, input int lead);
        int goal;
        int remaining;
        int step;
        goal = ((target * LINE_TICKS - lead) % FRAME_TICKS + FRAME_TICKS) % FRAME_TICKS;
        remaining = (goal - (ticks_sent + RESET_PHASE) % FRAME_TICKS + FRAME_TICKS)
                    % FRAME_TICKS;
        while (remaining > 0) begin
            step = (remaining > MAX_COUNT) ? MAX_COUNT : remaining;
            send_beat(step[CNT_W-1:0]);
            remaining -= step;
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (results_seen < beats_sent) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    task automatic load_config(input logic [7:0] cmp, input logic coinc_en,
                               input logic vblank_en, input logic search_en);
        cfg_write(REG_LINE_COMPARE, cmp);
        cfg_write(REG_IRQ_COINC, {7'b0, coinc_en});
        cfg_write(REG_IRQ_VBLANK, {7'b0, vblank_en});
        cfg_write(REG_IRQ_SEARCH, {7'b0, search_en});
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_lcd_mode_line_timer_core: done, errors");
        $finish;
    end

    initial begin
        logic [7:0] cmp;
        int         target;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b1;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_LINE_COMPARE;
        i_cfg_wdata   = '0;
        quiet         = 1'b0;
        ready_hold    = 0;
        beats_sent    = 0;
        ticks_sent    = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // line 1 gives coincidence and search entry in the same beat
        load_config(8'd1, 1'b1, 1'b1, 1'b1);
        foreach (opening_counts[n]) send_beat(opening_counts[n][CNT_W-1:0]);
        random_run(100);
        settle();

        // vblank entry on the compared line
        load_config(8'd144, 1'b1, 1'b1, 1'b0);
        run_to_line(VISIBLE_LINES, 150);
        random_run(100);
        settle();

        // frame wrap back to line 0
        load_config(8'd0, 1'b1, 1'b0, 1'b1);
        run_to_line(0, 120);
        random_run(100);
        settle();

        // compare value past the last line never matches
        load_config(8'hff, 1'b1, 1'b1, 1'b1);
        random_run(100);
        settle();

        // compare a few lines ahead of the current one, or at times a value past the last line
        for (int phase = 0; phase < 3; phase++) begin
            target = (ticks_sent + RESET_PHASE) % FRAME_TICKS / LINE_TICKS
                     + int'($urandom_range(2, 4));
            cmp = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(154, 255))
                                              : 8'(target % (VISIBLE_LINES + BLANK_LINES));
            load_config(cmp, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
            run_to_line(target, $urandom_range(0, 100));
            random_run(80);
            settle();
        end

        // closing stretch without any idling
        quiet = 1'b1;
        load_config(8'($urandom_range(0, 160)), 1'b1, 1'b1, 1'b1);
        random_run(100);
        settle();

        if (fail_count == 0 && waiting == 0) begin
            $display("tb_lcd_mode_line_timer_core: done, clean");
        end else begin
            $display("tb_lcd_mode_line_timer_core: done, errors");
        end
        $finish;
    end

endmodule
